>>> rtl/core/tbkc_pkg.sv
// Shared types, widths and register codes for the tile band knot concordance block.
package tbkc_pkg;

    localparam int TILE_BITS = 16;
    localparam int STEP_W    = 17;
    localparam int COUNT_W   = 17;
    localparam int WSTART_W  = 16;
    localparam int WCOUNT_W  = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    localparam logic [STEP_W-1:0]  MAX_STEPS = 17'd65536;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_START = 2'd0,
        REG_WINDOW_COUNT = 2'd1,
        REG_HIGH_QUALITY = 2'd2
    } cfg_reg_t;

    // One tile step as held in the input register
    typedef struct packed {
        logic signed [TILE_BITS-1:0] a_tile_first;
        logic signed [TILE_BITS-1:0] a_tile_second;
        logic signed [TILE_BITS-1:0] b_tile_first;
        logic signed [TILE_BITS-1:0] b_tile_second;
        logic                        a_low_quality;
        logic                        b_low_quality;
        logic                        last_step;
    } item_t;

    // Counts reported at the end of a band pair
    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic [COUNT_W-1:0] total_count;
    } result_t;

    // Handoff from the input register to the knot core
    typedef struct packed {
        logic  fire;
        item_t item;
    } step_t;

endpackage

>>> rtl/core/tbkc_in_stage.sv
// Input register: captures one tile step per transaction and hands it to the core.
module tbkc_in_stage
    import tbkc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  s_tlast,
    input  logic                  out_free,
    output step_t                 step
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_in;
    logic  advance;

    // A step without a result always moves on; a last step needs the output slot
    assign advance  = valid_reg && (!item_reg.last_step || out_free);
    assign s_tready = !valid_reg || advance;

    // Unpack the incoming transaction
    always_comb
    begin
        item_in.a_tile_first  = s_tdata[15:0];
        item_in.a_tile_second = s_tdata[31:16];
        item_in.b_tile_first  = s_tdata[47:32];
        item_in.b_tile_second = s_tdata[63:48];
        item_in.a_low_quality = s_tuser[0];
        item_in.b_low_quality = s_tuser[1];
        item_in.last_step     = s_tlast;
    end

    // Hold or refill the input register
    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg <= item_in;
        end
    end

    assign step.fire = advance;
    assign step.item = item_reg;

endmodule

>>> rtl/core/tbkc_knot_core.sv
// Knot tracking core: configuration registers, per-run state and the count update.
module tbkc_knot_core
    import tbkc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  step_t                 step,
    output logic                  res_valid,
    output result_t               res
);

    // Configuration
    logic [WSTART_W-1:0] window_start_reg;
    logic [WCOUNT_W-1:0] window_count_reg;
    logic                high_quality_reg;

    // Run state
    logic [STEP_W-1:0]   step_index_reg, step_index_next;
    logic                aligned_started_reg, aligned_started_next;
    logic                cand_open_reg, cand_open_next;
    logic                a_closed_reg, a_closed_next;
    logic                b_closed_reg, b_closed_next;
    logic                values_equal_reg, values_equal_next;
    logic                a_lowq_reg, a_lowq_next;
    logic                b_lowq_reg, b_lowq_next;
    result_t             counts_reg, counts_next;

    logic                a_start;
    logic                b_start;
    logic                same;
    logic                a_open;
    logic                b_open;
    logic                in_window;
    logic [STEP_W:0]     window_end;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Count a closed pair unless quality filtering rejects it
    function automatic result_t finish_pair(input result_t c, input logic hq,
                                            input logic alq, input logic blq,
                                            input logic veq);
        result_t r;
        r = c;
        if (!hq || (!alq && !blq))
        begin
            r.total_count = sat_inc(c.total_count);
            if (veq)
            begin
                r.match_count = sat_inc(c.match_count);
            end
        end
        finish_pair = r;
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= '0;
            window_count_reg <= '0;
            high_quality_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WINDOW_START: window_start_reg <= cfg_data[WSTART_W-1:0];
                REG_WINDOW_COUNT: window_count_reg <= cfg_data[WCOUNT_W-1:0];
                REG_HIGH_QUALITY: high_quality_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Step decode
    assign a_start = !step.item.a_tile_first[TILE_BITS-1]
                  && !step.item.a_tile_second[TILE_BITS-1];
    assign b_start = !step.item.b_tile_first[TILE_BITS-1]
                  && !step.item.b_tile_second[TILE_BITS-1];
    assign same    = (step.item.a_tile_first == step.item.b_tile_first)
                  && (step.item.a_tile_second == step.item.b_tile_second);
    assign a_open  = !a_closed_reg;
    assign b_open  = !b_closed_reg;

    assign window_end = {2'b00, window_start_reg} + {1'b0, window_count_reg};
    assign in_window  = (step_index_reg >= {1'b0, window_start_reg})
                     && ((window_count_reg == '0) || ({1'b0, step_index_reg} < window_end));

    // Advance the run state by one step
    always_comb
    begin
        step_index_next      = step_index_reg;
        aligned_started_next = aligned_started_reg;
        cand_open_next       = cand_open_reg;
        a_closed_next        = a_closed_reg;
        b_closed_next        = b_closed_reg;
        values_equal_next    = values_equal_reg;
        a_lowq_next          = a_lowq_reg;
        b_lowq_next          = b_lowq_reg;
        counts_next          = counts_reg;
        res_valid            = 1'b0;
        res                  = counts_reg;

        if (step.fire)
        begin
            // Extend or close the open knots of the current pair
            if (cand_open_reg)
            begin
                if (a_open)
                begin
                    if (a_start)
                    begin
                        a_closed_next = 1'b1;
                        if (!(b_open && b_start))
                        begin
                            values_equal_next = 1'b0;
                        end
                    end
                    else
                    begin
                        if (step.item.a_low_quality)
                        begin
                            a_lowq_next = 1'b1;
                        end
                        if (!same)
                        begin
                            values_equal_next = 1'b0;
                        end
                    end
                end
                if (b_open)
                begin
                    if (b_start)
                    begin
                        b_closed_next = 1'b1;
                        if (!(a_open && a_start))
                        begin
                            values_equal_next = 1'b0;
                        end
                    end
                    else if (step.item.b_low_quality)
                    begin
                        b_lowq_next = 1'b1;
                    end
                end
                if (a_closed_next && b_closed_next)
                begin
                    counts_next    = finish_pair(counts_next, high_quality_reg,
                                                 a_lowq_next, b_lowq_next,
                                                 values_equal_next);
                    cand_open_next = 1'b0;
                end
            end

            // Open a new aligned pair inside the window
            if (in_window && a_start && b_start)
            begin
                aligned_started_next = 1'b1;
                cand_open_next       = 1'b1;
                a_closed_next        = 1'b0;
                b_closed_next        = 1'b0;
                a_lowq_next          = step.item.a_low_quality;
                b_lowq_next          = step.item.b_low_quality;
                values_equal_next    = same;
            end

            if (step_index_reg < MAX_STEPS)
            begin
                step_index_next = step_index_reg + 1'b1;
            end

            // Band end: close the pair, report, and clear the run
            if (step.item.last_step)
            begin
                if (cand_open_next)
                begin
                    counts_next = finish_pair(counts_next, high_quality_reg,
                                              a_lowq_next, b_lowq_next,
                                              values_equal_next);
                end
                res_valid            = 1'b1;
                res                  = counts_next;
                step_index_next      = '0;
                aligned_started_next = 1'b0;
                cand_open_next       = 1'b0;
                a_closed_next        = 1'b0;
                b_closed_next        = 1'b0;
                values_equal_next    = 1'b0;
                a_lowq_next          = 1'b0;
                b_lowq_next          = 1'b0;
                counts_next          = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_index_reg      <= '0;
            aligned_started_reg <= 1'b0;
            cand_open_reg       <= 1'b0;
            a_closed_reg        <= 1'b0;
            b_closed_reg        <= 1'b0;
            values_equal_reg    <= 1'b0;
            a_lowq_reg          <= 1'b0;
            b_lowq_reg          <= 1'b0;
            counts_reg          <= '0;
        end
        else
        begin
            step_index_reg      <= step_index_next;
            aligned_started_reg <= aligned_started_next;
            cand_open_reg       <= cand_open_next;
            a_closed_reg        <= a_closed_next;
            b_closed_reg        <= b_closed_next;
            values_equal_reg    <= values_equal_next;
            a_lowq_reg          <= a_lowq_next;
            b_lowq_reg          <= b_lowq_next;
            counts_reg          <= counts_next;
        end
    end

endmodule

>>> rtl/core/tbkc_out_stage.sv
// Result register: holds the counts of a finished run until the transaction completes.
module tbkc_out_stage
    import tbkc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   res_valid,
    input  result_t                res,
    output logic                   out_free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    // Load on a new result, drop once taken
    always_comb
    begin
        valid_next = valid_reg;
        if (m_tready)
        begin
            valid_next = 1'b0;
        end
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0, res_reg.total_count, res_reg.match_count};

endmodule

>>> rtl/core/tile_band_knot_concordance_top.sv
// Top level of the tile band knot concordance block.
//
//   channel   direction  fields (lowest bit first)
//   s_*       in         tdata: a_tile_first, a_tile_second, b_tile_first, b_tile_second
//                        tuser: a_low_quality, b_low_quality; tlast: last_step
//   m_*       out        tdata: match_count, total_count, zero pad to 40 bits
//   cfg_*     in         index 0 window_start, 1 window_count, 2 high_quality_only
//
// One tile step is accepted every cycle unless a last step stalls; the core registers the run state.
// The result is loaded into the result register as the last step of a run leaves the input register.
// Only a last step waits for a stalled result register; other steps keep flowing.
// Reset clears the run state and sets high_quality_only; no clearing pass is needed.
module tile_band_knot_concordance_top
    import tbkc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // a_tile_first, a_tile_second, b_tile_first, b_tile_second
    input  logic [IN_USER_W-1:0]   s_tuser,   // a_low_quality, b_low_quality
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // match_count, total_count, pad
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    step_t   step;
    logic    out_free;
    logic    res_valid;
    result_t res;

    tbkc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .out_free (out_free),
        .step     (step)
    );

    tbkc_knot_core u_knot_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .res_valid (res_valid),
        .res       (res)
    );

    tbkc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef ASSERT_OFF
    // A result never overwrites one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending transaction");

    // Only a last step produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (step.fire && step.item.last_step))
        else $error("result without a last step");

    // Matches are a subset of the counted pairs
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16:0] <= m_tdata[33:17]))
        else $error("match count exceeds total count");

    // A new result follows a last step that fired in the previous cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(step.fire && step.item.last_step))
        else $error("result raised without a finished run");
`endif

endmodule
